/* src/assert_macros.svh */
// assertion macros used by the parser top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* src/afp_pkg.sv */
// types and constants of the frame parser
package afp_pkg;

  localparam int DEF_MAX_FIELDS      = 8;
  localparam int DEF_MAX_FIELD_CHARS = 9;
  localparam int DEF_QUEUE_DEPTH     = 4;

  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_VT      = 8'h0B;
  localparam logic [7:0] CH_FF      = 8'h0C;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  typedef enum logic [2:0] {
    KIND_START,
    KIND_SEP,
    KIND_END,
    KIND_DIGIT,
    KIND_SPACE,
    KIND_PLUS,
    KIND_MINUS,
    KIND_OTHER
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] digit;
  } cls_t;

endpackage

/* src/afp_front.sv */
// byte classifier feeding the beat queue
module afp_front (
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    rx_byte,
  output logic          q_valid,
  input  logic          q_ready,
  output afp_pkg::cls_t q_data
);
  import afp_pkg::*;

  assign q_valid  = in_valid;
  assign in_ready = q_ready;

  always_comb begin
    q_data.digit = rx_byte[3:0];
    if (rx_byte == CH_PERCENT) begin
      q_data.kind = KIND_START;
    end else if (rx_byte == CH_COMMA) begin
      q_data.kind = KIND_SEP;
    end else if (rx_byte == CH_LF) begin
      q_data.kind = KIND_END;
    end else if (rx_byte inside {[CH_ZERO:CH_NINE]}) begin
      q_data.kind = KIND_DIGIT;
    end else if (rx_byte inside {CH_TAB, CH_VT, CH_FF, CH_CR, CH_SPACE}) begin
      q_data.kind = KIND_SPACE;
    end else if (rx_byte == CH_PLUS) begin
      q_data.kind = KIND_PLUS;
    end else if (rx_byte == CH_MINUS) begin
      q_data.kind = KIND_MINUS;
    end else begin
      q_data.kind = KIND_OTHER;
    end
  end

endmodule

/* src/afp_queue.sv */
// short register queue between classifier and parser
module afp_queue #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

/* src/afp_back.sv */
// field parser and result register
module afp_back #(
  parameter int MAX_FIELDS      = afp_pkg::DEF_MAX_FIELDS,
  parameter int MAX_FIELD_CHARS = afp_pkg::DEF_MAX_FIELD_CHARS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_ready,
  input  afp_pkg::cls_t q_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   field_value,
  output logic [3:0]    field_index,
  output logic          value_valid,
  output logic          frame_end,
  output logic          frame_overflow
);
  import afp_pkg::*;

  localparam logic [31:0] SAT_MAG = 32'h8000_0000;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

  logic        in_frame, in_frame_next;
  logic        first_pending, first_pending_next;
  logic [31:0] accumulator, accumulator_next;
  logic        negative, negative_next;
  logic        digits_done, digits_done_next;
  logic        started, started_next;
  logic [3:0]  char_count, char_count_next;
  logic [3:0]  field_count, field_count_next;
  logic        overflowed, overflowed_next;

  logic        pop;
  logic        res;
  logic        emit;
  logic        is_end;
  logic [35:0] prod;
  logic [31:0] result_value;

  assign q_ready = !out_valid || out_ready;
  assign pop     = q_valid && q_ready;
  assign prod    = ({4'd0, accumulator} << 3) + ({4'd0, accumulator} << 1)
                   + {32'd0, q_data.digit};
  assign result_value = negative ? (32'd0 - accumulator)
                        : (accumulator[31] ? POS_MAX : accumulator);

  always_comb begin
    in_frame_next      = in_frame;
    first_pending_next = first_pending;
    accumulator_next   = accumulator;
    negative_next      = negative;
    digits_done_next   = digits_done;
    started_next       = started;
    char_count_next    = char_count;
    field_count_next   = field_count;
    overflowed_next    = overflowed;
    res                = 1'b0;
    emit               = 1'b0;
    is_end             = (q_data.kind == KIND_END);
    if (q_data.kind == KIND_START) begin
      in_frame_next      = 1'b1;
      first_pending_next = 1'b1;
      field_count_next   = '0;
      overflowed_next    = 1'b0;
      accumulator_next   = '0;
      negative_next      = 1'b0;
      digits_done_next   = 1'b0;
      started_next       = 1'b0;
      char_count_next    = '0;
    end else if (in_frame) begin
      case (q_data.kind)
        KIND_SEP, KIND_END: begin
          if (!first_pending || char_count != '0) begin
            if (field_count < 4'(MAX_FIELDS)) begin
              field_count_next = field_count + 1'b1;
              emit             = 1'b1;
            end else begin
              overflowed_next = 1'b1;
            end
          end
          res                = emit || is_end;
          first_pending_next = 1'b0;
          accumulator_next   = '0;
          negative_next      = 1'b0;
          digits_done_next   = 1'b0;
          started_next       = 1'b0;
          char_count_next    = '0;
          if (is_end) begin
            in_frame_next = 1'b0;
          end
        end
        default: begin
          if (char_count < 4'(MAX_FIELD_CHARS)) begin
            char_count_next = char_count + 1'b1;
            if (!digits_done) begin
              if (q_data.kind == KIND_DIGIT) begin
                accumulator_next = (prod > {4'd0, SAT_MAG}) ? SAT_MAG : prod[31:0];
                started_next     = 1'b1;
              end else if (!started && q_data.kind == KIND_SPACE) begin
                started_next = 1'b0;
              end else if (!started && (q_data.kind == KIND_PLUS
                                        || q_data.kind == KIND_MINUS)) begin
                negative_next = (q_data.kind == KIND_MINUS);
                started_next  = 1'b1;
              end else begin
                digits_done_next = 1'b1;
              end
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      first_pending <= 1'b0;
      accumulator   <= '0;
      negative      <= 1'b0;
      digits_done   <= 1'b0;
      started       <= 1'b0;
      char_count    <= '0;
      field_count   <= '0;
      overflowed    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (pop) begin
        in_frame      <= in_frame_next;
        first_pending <= first_pending_next;
        accumulator   <= accumulator_next;
        negative      <= negative_next;
        digits_done   <= digits_done_next;
        started       <= started_next;
        char_count    <= char_count_next;
        field_count   <= field_count_next;
        overflowed    <= overflowed_next;
      end
      if (pop && res) begin
        out_valid      <= 1'b1;
        field_value    <= emit ? result_value : '0;
        field_index    <= emit ? field_count_next : '0;
        value_valid    <= emit;
        frame_end      <= is_end;
        frame_overflow <= overflowed_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* src/ascii_command_frame_parser.sv */
// top level of the ascii comma separated integer frame parser
// a field's closing beat passes through the queue entry, then its result is held in the parser's output register
// throughput: one byte per cycle while the queue has room and no output stall holds the parser
// the classifier queue absorbs output stalls of up to QUEUE_DEPTH beats
// reset: synchronous, empties the queue, drops any frame and clears the result
`include "assert_macros.svh"
module ascii_command_frame_parser #(
  parameter int MAX_FIELDS      = afp_pkg::DEF_MAX_FIELDS,
  parameter int MAX_FIELD_CHARS = afp_pkg::DEF_MAX_FIELD_CHARS,
  parameter int QUEUE_DEPTH     = afp_pkg::DEF_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] field_value,
  output logic [3:0]  field_index,
  output logic        value_valid,
  output logic        frame_end,
  output logic        frame_overflow
);
  import afp_pkg::*;

  logic f_valid, f_ready;
  cls_t f_data;
  logic b_valid, b_ready;
  cls_t b_data;

  afp_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .q_valid  (f_valid),
    .q_ready  (f_ready),
    .q_data   (f_data)
  );

  afp_queue #(
    .WIDTH ($bits(cls_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  afp_back #(
    .MAX_FIELDS      (MAX_FIELDS),
    .MAX_FIELD_CHARS (MAX_FIELD_CHARS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (b_valid),
    .q_ready        (b_ready),
    .q_data         (b_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .field_value    (field_value),
    .field_index    (field_index),
    .value_valid    (value_valid),
    .frame_end      (frame_end),
    .frame_overflow (frame_overflow)
  );

  // an emitted field carries a position inside the frame limit
  `ASSERT_IMPLIES(a_index_range, clk, rst, out_valid && value_valid, field_index != 4'd0 && field_index <= 4'(MAX_FIELDS), "field index out of range")
  // a beat without a value only closes a frame and carries zeros
  `ASSERT_IMPLIES(a_empty_is_end, clk, rst, out_valid && !value_valid, frame_end && field_value == 32'd0 && field_index == 4'd0, "empty result not at frame end")
  // no value once the frame has overflowed
  `ASSERT_IMPLIES(a_no_value_after_ovf, clk, rst, out_valid && value_valid, !frame_overflow, "value emitted after overflow")

endmodule

/* verif/tb_top.sv */
// self-checking testbench of the ascii comma separated integer frame parser
module tb_top;
  import afp_pkg::*;

  localparam int FIELD_LIMIT = DEF_MAX_FIELDS;
  localparam int CHAR_LIMIT  = DEF_MAX_FIELD_CHARS;
  localparam logic [32:0] SAT_MAG = 33'h080000000;

  typedef struct packed {
    logic [31:0] value;
    logic [3:0]  index;
    logic        has_value;
    logic        closes_frame;
    logic        overflow;
  } field_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] field_value;
  logic [3:0]  field_index;
  logic        value_valid;
  logic        frame_end;
  logic        frame_overflow;

  ascii_command_frame_parser DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .field_value(field_value),
    .field_index(field_index),
    .value_valid(value_valid),
    .frame_end(frame_end),
    .frame_overflow(frame_overflow)
  );

  // parser state as the predictor sees it
  logic        in_frame = 1'b0;
  logic        first_pending = 1'b0;
  logic [32:0] magnitude = '0;
  logic        negative = 1'b0;
  logic        digits_done = 1'b0;
  logic [3:0]  char_count = '0;
  logic [3:0]  field_count = '0;
  logic        overflowed = 1'b0;
  logic        number_started = 1'b0;

  field_result_t parsed_fields[$];
  field_result_t want;
  int errors = 0;
  int frame_bytes = 0;
  bit valid_up = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAIL ascii_command_frame_parser");
    $finish;
  end

  function automatic logic is_blank(input logic [7:0] b);
    return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
  endfunction

  task automatic clear_field();
    magnitude = '0;
    negative = 1'b0;
    digits_done = 1'b0;
    char_count = '0;
    number_started = 1'b0;
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    logic [35:0] wide;
    logic [32:0] mag;
    logic emit;
    field_result_t res;
    emit = 1'b0;
    if (b == CH_PERCENT) begin
      frame_bytes++;
      in_frame = 1'b1;
      first_pending = 1'b1;
      field_count = '0;
      overflowed = 1'b0;
      clear_field();
    end else if (in_frame) begin
      frame_bytes++;
      if (b != CH_COMMA && b != CH_LF) begin
        if (char_count < 4'(CHAR_LIMIT)) begin
          char_count++;
          if (!digits_done) begin
            if (b >= CH_ZERO && b <= CH_NINE) begin
              wide = 36'(magnitude) * 36'd10 + 36'(b - CH_ZERO);
              magnitude = (wide > SAT_MAG) ? SAT_MAG : wide[32:0];
              number_started = 1'b1;
            end else if (!number_started && is_blank(b)) begin
            end else if (!number_started && (b == CH_PLUS || b == CH_MINUS)) begin
              negative = (b == CH_MINUS);
              number_started = 1'b1;
            end else begin
              digits_done = 1'b1;
            end
          end
        end
      end else begin
        if (!first_pending || char_count != '0) begin
          if (field_count < 4'(FIELD_LIMIT)) begin
            field_count++;
            emit = 1'b1;
          end else begin
            overflowed = 1'b1;
          end
        end
        mag = magnitude;
        if (negative) begin
          if (mag > SAT_MAG) mag = SAT_MAG;
          res.value = 32'd0 - mag[31:0];
        end else begin
          if (mag > 33'h07fffffff) mag = 33'h07fffffff;
          res.value = mag[31:0];
        end
        if (!emit) res.value = '0;
        res.index = emit ? field_count : 4'd0;
        res.has_value = emit;
        res.closes_frame = (b == CH_LF);
        res.overflow = overflowed;
        first_pending = 1'b0;
        clear_field();
        if (b == CH_LF) in_frame = 1'b0;
        if (emit || b == CH_LF) parsed_fields.push_back(res);
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    rx_byte <= b;
    if (!valid_up) in_valid <= 1'b1;
    valid_up = 1;
    do @(posedge clk); while (!in_ready);
    parse_rx_byte(b);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        valid_up = 0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic hold_until_drained();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 0;
    end
    while (parsed_fields.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 4))
      0: return CH_TAB;
      1: return CH_VT;
      2: return CH_FF;
      3: return CH_CR;
      default: return CH_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] junk_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_PERCENT || b == CH_COMMA || b == CH_LF || (b >= CH_ZERO && b <= CH_NINE));
    return b;
  endfunction

  task automatic send_field();
    int n;
    bit nines;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) send_byte(blank_byte());
    case ($urandom_range(0, 2))
      0: send_byte(CH_PLUS);
      1: send_byte(CH_MINUS);
      default: ;
    endcase
    n = $urandom_range(0, 7) == 0 ? 0 :
        ($urandom_range(0, 4) == 0 ? $urandom_range(8, 12) : $urandom_range(1, 4));
    nines = ($urandom_range(0, 5) == 0);
    for (int i = 0; i < n; i++) begin
      send_byte(nines ? CH_NINE : 8'(CH_ZERO + $urandom_range(0, 9)));
      if ($urandom_range(0, 40) == 0) send_byte(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 7) == 0) begin
      send_byte(junk_byte());
      repeat ($urandom_range(0, 3)) send_byte(8'(CH_ZERO + $urandom_range(0, 9)));
    end
  endtask

  task automatic send_frame(input bit closed);
    int nf;
    nf = $urandom_range(0, 5) == 0 ? $urandom_range(9, 11) : $urandom_range(0, 8);
    send_byte(CH_PERCENT);
    for (int f = 0; f < nf; f++) begin
      if (f > 0) send_byte(CH_COMMA);
      send_field();
    end
    if (closed) send_byte(CH_LF);
  endtask

  task automatic test_idle_bytes();
    send_text("z\n,");
  endtask

  task automatic test_empty_frames();
    send_text("%\n%,\n");
  endtask

  task automatic test_field_forms();
    send_text("% -42,+7,\t3x9,\n");
  endtask

  task automatic test_long_field_and_restart();
    send_text("%9999999999%12\n");
  endtask

  task automatic test_too_many_fields();
    send_text("%1,2,3,4,5,6,7,8,9\n");
  endtask

  task automatic test_random_frames();
    int goal;
    int next_hold;
    goal = frame_bytes + 1600;
    next_hold = frame_bytes + 400;
    while (frame_bytes < goal) begin
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
        1: send_frame(0);
        default: send_frame(1);
      endcase
      if (frame_bytes >= next_hold) begin
        hold_until_drained();
        next_hold = frame_bytes + 400;
      end
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] exp,
                                      input logic [31:0] act);
    if (exp !== act) begin
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, exp, act);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (parsed_fields.size() == 0) begin
        $display("%0t unexpected beat: expected none actual value %0h index %0d",
                 $time, field_value, field_index);
        errors++;
      end else begin
        want = parsed_fields.pop_front();
        check_field("field_value", want.value, field_value);
        check_field("field_index", 32'(want.index), 32'(field_index));
        check_field("value_valid", 32'(want.has_value), 32'(value_valid));
        check_field("frame_end", 32'(want.closes_frame), 32'(frame_end));
        check_field("frame_overflow", 32'(want.overflow), 32'(frame_overflow));
      end
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 160);
    end
    stall_left--;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 7) != 0);
      default: out_ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_idle_bytes();
    test_empty_frames();
    test_field_forms();
    test_long_field_and_restart();
    test_too_many_fields();
    hold_until_drained();
    test_random_frames();
    hold_until_drained();
    repeat (8) @(posedge clk);
    if (parsed_fields.size() != 0) begin
      $display("%0t results missing: expected %0d more actual 0", $time,
               parsed_fields.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASS ascii_command_frame_parser");
    end else begin
      $display("FAIL ascii_command_frame_parser");
    end
    $finish;
  end

endmodule
